/* hdl/sbrt_pkg.sv */
// Package for the split block reassembly tracker.
// Holds the item structs, result kind codes, decoder constants and the sequencer states.
// Depends on nothing.
package sbrt_pkg;

	localparam logic [31:0] SINGLE_LIMIT  = 32'd10000;
	localparam logic [13:0] TOTAL_SCALE   = 14'd1000;
	localparam logic [31:0] TIMEOUT_RESET = 32'd5000;
	localparam int          MAX_PARTS     = 9;
	localparam logic [3:0]  MAX_RESULTS   = 4'd9;

	localparam logic [1:0] KIND_PART = 2'd0;
	localparam logic [1:0] KIND_DROP = 2'd1;
	localparam logic [1:0] KIND_FULL = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic [31:0] coded_id;
		logic [2:0]  priority_req;
		logic [15:0] buffer_handle;
		logic [15:0] block_length;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] frame_id;
		logic [2:0]  frame_priority;
		logic [3:0]  part_index;
		logic [15:0] part_handle;
		logic [15:0] part_length;
		logic        last;
	} out_item_t;

	// Decoded split id, handed from the decoder to the sequencer.
	typedef struct packed {
		logic [18:0] base;
		logic [3:0]  total;
		logic [9:0]  index;
	} id_dec_t;

	// One row of the context memory.
	typedef struct packed {
		logic [18:0] base;
		logic [3:0]  total;
		logic [2:0]  prio;
		logic [31:0] start;
		logic [8:0]  rmap;
	} ctx_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SINGLE,
		ST_DIV,
		ST_LOOK_RD,
		ST_LOOK_CHK,
		ST_HIT,
		ST_NEW,
		ST_EMIT_RD,
		ST_EMIT_PUSH,
		ST_TICK_RD,
		ST_TICK_CHK,
		ST_TICK_FLUSH
	} state_t;

endpackage

/* hdl/split_block_reassembly_tracker_unit.sv */
// Split block reassembly tracker. A block with an id below 10000 passes straight through.
// A split block passes through the id decoder pipeline, then is checked against one
// context at a time through the single read port of the context memory, is filed, and
// has its parts sent one by one when its frame completes. A tick walks the context
// memory one context at a time and ends with a step that sends the last drop report.
// Stalls on the result side can hold any of these steps. Contexts live in a memory with
// per-context valid flip-flops, so no clearing pass follows reset.
module split_block_reassembly_tracker_unit import sbrt_pkg::*; #(
	parameter int NUM_CONTEXTS = 8,
	parameter int HANDLE_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam int CIW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
	localparam int SW  = $clog2(NUM_CONTEXTS + 1) + 1;
	localparam int PD  = NUM_CONTEXTS * MAX_PARTS;
	localparam int PAW = (PD > 1) ? $clog2(PD) : 1;
	localparam int HW  = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

	state_t            state_q, state_d;
	in_item_t          in_q;
	logic [31:0]       timeout_q;
	logic [NUM_CONTEXTS-1:0] valid_q;
	logic [SW-1:0]     scan_q;
	logic [CIW-1:0]    slot_q;
	logic [3:0]        i_q;
	logic [3:0]        nres_q;
	logic [2:0]        eprio_q;
	logic [3:0]        etot_q;
	logic              pend_v_q;
	out_item_t         pend_q;
	logic              out_valid_q;
	out_item_t         out_q;
	id_dec_t           dec_q;

	// Memories.
	ctx_entry_t        ctx_mem [NUM_CONTEXTS];
	ctx_entry_t        ctx_rd_q;
	logic [HW+15:0]    part_mem [PD];
	logic [HW+15:0]    part_rd_q;

	logic              dec_start, dec_done;
	id_dec_t           dec_res;

	logic [CIW-1:0]    scan_idx;
	logic              scan_end;
	logic              free_any;
	logic [CIW-1:0]    free_idx;
	logic              out_free;
	logic [8:0]        idx_bit;
	logic [8:0]        hit_map, new_full;
	logic [15:0]       rmap_sh;
	logic              hit_ok, expired;

	logic              ctx_rd_en, ctx_we, part_rd_en, part_we;
	logic [CIW-1:0]    ctx_waddr;
	ctx_entry_t        ctx_wdata;
	logic [PAW-1:0]    part_addr;
	logic              push;
	out_item_t         push_data;

	sbrt_id_decode u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dec_start),
		.sid    (in_data.coded_id),
		.done   (dec_done),
		.res    (dec_res)
	);

	// Shared decode of the current scan position and table state.
	always_comb begin
		scan_idx = scan_q[CIW-1:0];
		scan_end = scan_q == SW'(NUM_CONTEXTS);
		out_free = !out_valid_q || out_ready;
		free_any = 1'b0;
		free_idx = '0;
		for (int c = NUM_CONTEXTS - 1; c >= 0; c--) begin
			if (!valid_q[c]) begin
				free_any = 1'b1;
				free_idx = CIW'(c);
			end
		end
		idx_bit  = 9'(16'(1) << dec_q.index[3:0]);
		rmap_sh  = 16'(ctx_rd_q.rmap) >> dec_q.index[3:0];
		hit_ok   = (dec_q.index < 10'(ctx_rd_q.total)) && !rmap_sh[0];
		hit_map  = ctx_rd_q.rmap | idx_bit;
		new_full = 9'((10'(1) << dec_q.total) - 10'(1));
		expired  = valid_q[scan_idx] && ((in_q.now_ms - ctx_rd_q.start) > timeout_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_data.opcode) begin
						state_d = ST_TICK_RD;
					end else if (in_data.coded_id < SINGLE_LIMIT) begin
						state_d = ST_SINGLE;
					end else begin
						state_d = ST_DIV;
					end
				end
			end
			ST_SINGLE: if (out_free) state_d = ST_IDLE;
			ST_DIV: if (dec_done) state_d = ST_LOOK_RD;
			ST_LOOK_RD: state_d = scan_end ? ST_NEW : ST_LOOK_CHK;
			ST_LOOK_CHK: begin
				if (valid_q[scan_idx] && ctx_rd_q.base == dec_q.base) begin
					state_d = ST_HIT;
				end else begin
					state_d = ST_LOOK_RD;
				end
			end
			ST_HIT: begin
				if (hit_ok && hit_map == 9'((10'(1) << ctx_rd_q.total) - 10'(1))) begin
					state_d = ST_EMIT_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_NEW: begin
				if (dec_q.index >= 10'(dec_q.total)) begin
					state_d = ST_IDLE;
				end else if (!free_any) begin
					if (out_free) state_d = ST_IDLE;
				end else if (idx_bit == new_full) begin
					state_d = ST_EMIT_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT_RD: state_d = ST_EMIT_PUSH;
			ST_EMIT_PUSH: begin
				if (out_free) begin
					state_d = (i_q + 4'd1 == etot_q) ? ST_IDLE : ST_EMIT_RD;
				end
			end
			ST_TICK_RD: begin
				state_d = (scan_end || nres_q == MAX_RESULTS) ? ST_TICK_FLUSH : ST_TICK_CHK;
			end
			ST_TICK_CHK: begin
				if (!(expired && pend_v_q && !out_free)) state_d = ST_TICK_RD;
			end
			ST_TICK_FLUSH: begin
				if (!pend_v_q || out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake, memory strobes and result pushes.
	always_comb begin
		in_ready   = state_q == ST_IDLE;
		dec_start  = 1'b0;
		ctx_rd_en  = 1'b0;
		ctx_we     = 1'b0;
		ctx_waddr  = slot_q;
		ctx_wdata  = ctx_rd_q;
		part_rd_en = 1'b0;
		part_we    = 1'b0;
		part_addr  = PAW'(slot_q) * PAW'(MAX_PARTS) + PAW'(i_q);
		push       = 1'b0;
		push_data  = pend_q;
		unique case (state_q)
			ST_IDLE: begin
				dec_start = in_valid && !in_data.opcode && in_data.coded_id >= SINGLE_LIMIT;
			end
			ST_SINGLE: begin
				push = out_free;
				push_data.kind           = KIND_PART;
				push_data.frame_id       = in_q.coded_id;
				push_data.frame_priority = in_q.priority_req;
				push_data.part_index     = 4'd0;
				push_data.part_handle    = 16'(in_q.buffer_handle[HW-1:0]);
				push_data.part_length    = in_q.block_length;
				push_data.last           = 1'b1;
			end
			ST_LOOK_RD, ST_TICK_RD: begin
				ctx_rd_en = !scan_end;
			end
			ST_HIT: begin
				ctx_we         = hit_ok;
				ctx_wdata.rmap = hit_map;
				part_we        = hit_ok;
				part_addr      = PAW'(slot_q) * PAW'(MAX_PARTS) + PAW'(dec_q.index[3:0]);
			end
			ST_NEW: begin
				if (dec_q.index < 10'(dec_q.total)) begin
					if (free_any) begin
						ctx_we          = 1'b1;
						ctx_waddr       = free_idx;
						ctx_wdata.base  = dec_q.base;
						ctx_wdata.total = dec_q.total;
						ctx_wdata.prio  = in_q.priority_req;
						ctx_wdata.start = in_q.now_ms;
						ctx_wdata.rmap  = idx_bit;
						part_we         = 1'b1;
						part_addr       = PAW'(free_idx) * PAW'(MAX_PARTS)
						                  + PAW'(dec_q.index[3:0]);
					end else begin
						push = out_free;
						push_data.kind           = KIND_FULL;
						push_data.frame_id       = 32'(dec_q.base);
						push_data.frame_priority = in_q.priority_req;
						push_data.part_index     = dec_q.index[3:0];
						push_data.part_handle    = 16'(in_q.buffer_handle[HW-1:0]);
						push_data.part_length    = in_q.block_length;
						push_data.last           = 1'b1;
					end
				end
			end
			ST_EMIT_RD: begin
				part_rd_en = 1'b1;
			end
			ST_EMIT_PUSH: begin
				push = out_free;
				push_data.kind           = KIND_PART;
				push_data.frame_id       = 32'(dec_q.base);
				push_data.frame_priority = eprio_q;
				push_data.part_index     = i_q;
				push_data.part_handle    = 16'(part_rd_q[HW+15:16]);
				push_data.part_length    = part_rd_q[15:0];
				push_data.last           = i_q + 4'd1 == etot_q;
			end
			ST_TICK_CHK: begin
				push = expired && pend_v_q && out_free;
			end
			ST_TICK_FLUSH: begin
				push = pend_v_q && out_free;
				push_data.last = 1'b1;
			end
			default: ;
		endcase
	end

	// Context memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (ctx_we) ctx_mem[ctx_waddr] <= ctx_wdata;
		if (ctx_rd_en) ctx_rd_q <= ctx_mem[scan_idx];
	end

	// Part descriptor memory: single port, read data registered.
	always_ff @(posedge clk) begin
		if (part_we) begin
			part_mem[part_addr] <= {in_q.buffer_handle[HW-1:0], in_q.block_length};
		end else if (part_rd_en) begin
			part_rd_q <= part_mem[part_addr];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			timeout_q   <= TIMEOUT_RESET;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			pend_v_q    <= 1'b0;
			scan_q      <= '0;
			nres_q      <= '0;
			i_q         <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) timeout_q <= cfg_wdata;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					scan_q   <= '0;
					nres_q   <= '0;
					i_q      <= '0;
					pend_v_q <= 1'b0;
				end
				ST_LOOK_CHK: scan_q <= scan_q + SW'(1);
				ST_NEW: begin
					if (dec_q.index < 10'(dec_q.total) && free_any) valid_q[free_idx] <= 1'b1;
				end
				ST_EMIT_PUSH: begin
					if (out_free) begin
						i_q <= i_q + 4'd1;
						if (i_q + 4'd1 == etot_q) valid_q[slot_q] <= 1'b0;
					end
				end
				ST_TICK_CHK: begin
					if (!expired) begin
						scan_q <= scan_q + SW'(1);
					end else if (!pend_v_q || out_free) begin
						scan_q            <= scan_q + SW'(1);
						pend_v_q          <= 1'b1;
						nres_q            <= nres_q + 4'd1;
						valid_q[scan_idx] <= 1'b0;
					end
				end
				ST_TICK_FLUSH: if (out_free) pend_v_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) in_q <= in_data;
		if (dec_done) dec_q <= dec_res;
		if (push) out_q <= push_data;
		if (state_q == ST_LOOK_CHK) slot_q <= scan_idx;
		if (state_q == ST_HIT) begin
			eprio_q <= ctx_rd_q.prio;
			etot_q  <= ctx_rd_q.total;
		end
		if (state_q == ST_NEW) begin
			slot_q  <= free_idx;
			eprio_q <= in_q.priority_req;
			etot_q  <= dec_q.total;
		end
		if (state_q == ST_TICK_CHK && expired && (!pend_v_q || out_free)) begin
			pend_q.kind           <= KIND_DROP;
			pend_q.frame_id       <= 32'(ctx_rd_q.base);
			pend_q.frame_priority <= ctx_rd_q.prio;
			pend_q.part_index     <= 4'd0;
			pend_q.part_handle    <= 16'd0;
			pend_q.part_length    <= 16'd0;
			pend_q.last           <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!out_valid_q || out_ready))
		else $error("result pushed over a waiting item");

	// Parts are only emitted from a live context.
	a_emit_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_PUSH) |-> valid_q[slot_q])
		else $error("emitting from a freed context");

	// The decoder only finishes while the sequencer waits for it.
	a_dec_wait: assert property (@(posedge clk) disable iff (!arst_n)
		dec_done |-> (state_q == ST_DIV))
		else $error("decoder finished outside its wait state");

	// The final part of a frame frees its context.
	a_free_after: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_PUSH && push && push_data.last) |=> !valid_q[$past(slot_q)])
		else $error("context not freed after its last part");
`endif

endmodule

/* hdl/sbrt_id_decode.sv */
// Split stream id decoder: base, total and index from a coded 32-bit id.
// Division by 10000 through a reciprocal multiply, pipelined as product, quotient and remainder, then digits.
// Depends on sbrt_pkg.
module sbrt_id_decode import sbrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] sid,
	output logic        done,
	output id_dec_t     res
);

	// Reciprocal of 10000 scaled by 2^45; the quotient is exact for every 32-bit id.
	localparam logic [31:0] RECIP_10K = 32'd3518437209;
	localparam int          RECIP_SH  = 45;

	logic        v_s1;
	logic        v_s2;
	logic        done_q;
	logic [63:0] prod_s1;
	logic [31:0] num_s1;
	logic [18:0] quo_s2;
	logic [13:0] rem_s2;
	id_dec_t     res_q;

	logic [18:0] quo;
	logic [31:0] rem_w;
	logic [3:0]  tot;
	logic [13:0] sub;

	// Quotient from the scaled product, remainder by one constant multiply and subtract.
	always_comb begin
		quo   = prod_s1[RECIP_SH +: 19];
		rem_w = num_s1 - 32'(quo) * SINGLE_LIMIT;
	end

	// The remainder is below 10000, so the total digit is a count of thresholds passed.
	always_comb begin
		tot = 4'd0;
		for (int k = 1; k <= 9; k++) begin
			if (rem_s2 >= 14'(k) * TOTAL_SCALE) begin
				tot = 4'(k);
			end
		end
		sub = rem_s2 - 14'(tot) * TOTAL_SCALE;
	end

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	// Data of the pipeline: a 32 by 32 product, then quotient and remainder, then digits.
	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= 64'(sid) * 64'(RECIP_10K);
			num_s1  <= sid;
		end
		if (v_s1) begin
			quo_s2 <= quo;
			rem_s2 <= rem_w[13:0];
		end
		if (v_s2) begin
			res_q.base  <= quo_s2;
			res_q.total <= tot;
			res_q.index <= 10'(sub);
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

/* dv/tb_split_block_reassembly_tracker_unit.sv */
// Testbench for the split block reassembly tracker: directed and random frames, ticks and
// table overflow, checked against an in-bench model of the context table.
// Depends on sbrt_pkg and split_block_reassembly_tracker_unit.
`timescale 1ns / 1ps

module tb_split_block_reassembly_tracker_unit;
	import sbrt_pkg::*;

	localparam int NCTX = 8;
	localparam logic OP_BLOCK = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	// Model state of the context table.
	logic        m_valid [NCTX];
	logic [31:0] m_base [NCTX];
	logic [3:0]  m_total [NCTX];
	logic [2:0]  m_prio [NCTX];
	logic [31:0] m_start [NCTX];
	logic [8:0]  m_map [NCTX];
	logic [15:0] m_hnd [NCTX][9];
	logic [15:0] m_len [NCTX][9];
	logic [31:0] m_timeout;

	out_item_t expected_results[$];
	int mismatches;
	int results_seen;
	int items_sent;
	int hold_off;
	int hold_req;
	int hold_ack;
	logic [31:0] clock_ms;

	split_block_reassembly_tracker_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic out_item_t mk(logic [1:0] k, logic [31:0] id, logic [2:0] p,
			logic [3:0] ix, logic [15:0] h, logic [15:0] l, logic lst);
		out_item_t r;
		r.kind = k; r.frame_id = id; r.frame_priority = p; r.part_index = ix;
		r.part_handle = h; r.part_length = l; r.last = lst;
		return r;
	endfunction

	// Append one expected result at the tail of the queue.
	function automatic void queue_result(input out_item_t r);
		expected_results.insert(expected_results.size(), r);
	endfunction

	// Predict results of one item and update the table model.
	task automatic predict_tracker(input in_item_t it);
		int n, slot;
		logic [31:0] base, rem, tot, idx;
		if (it.opcode == OP_TICK) begin
			n = 0;
			for (int c = 0; c < NCTX; c++) begin
				if (m_valid[c] && (it.now_ms - m_start[c]) > m_timeout) begin
					queue_result(mk(KIND_DROP, m_base[c], m_prio[c], 4'd0, 16'd0, 16'd0,
						1'b0));
					m_valid[c] = 1'b0;
					m_map[c] = '0;
					n++;
				end
			end
			if (n > 0) expected_results[expected_results.size() - 1].last = 1'b1;
			return;
		end
		if (it.coded_id < SINGLE_LIMIT) begin
			queue_result(mk(KIND_PART, it.coded_id, it.priority_req, 4'd0,
				it.buffer_handle, it.block_length, 1'b1));
			return;
		end
		base = it.coded_id / 10000;
		rem = it.coded_id % 10000;
		tot = rem / 1000;
		idx = rem % 1000;
		slot = -1;
		for (int c = 0; c < NCTX; c++)
			if (slot < 0 && m_valid[c] && m_base[c] == base) slot = c;
		if (slot < 0) begin
			if (idx >= tot) return;
			for (int c = 0; c < NCTX; c++)
				if (slot < 0 && !m_valid[c]) slot = c;
			if (slot < 0) begin
				queue_result(mk(KIND_FULL, base, it.priority_req, idx[3:0],
					it.buffer_handle, it.block_length, 1'b1));
				return;
			end
			m_valid[slot] = 1'b1; m_base[slot] = base; m_total[slot] = tot[3:0];
			m_prio[slot] = it.priority_req; m_start[slot] = it.now_ms; m_map[slot] = '0;
		end else if (idx >= m_total[slot]) return;
		if (m_map[slot][idx]) return;
		m_map[slot][idx] = 1'b1;
		m_hnd[slot][idx] = it.buffer_handle;
		m_len[slot][idx] = it.block_length;
		if (m_map[slot] != 9'((1 << m_total[slot]) - 1)) return;
		for (int i = 0; i < m_total[slot]; i++)
			queue_result(mk(KIND_PART, base, m_prio[slot], i[3:0],
				m_hnd[slot][i], m_len[slot][i], (i + 1 == m_total[slot])));
		m_valid[slot] = 1'b0;
		m_map[slot] = '0;
	endtask

	// Offer one item after a random gap and hold it until accepted.
	task automatic send_item(input in_item_t it);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
		if ($urandom_range(0, 3) == 0) gap = 1;
		repeat (gap) @(posedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		predict_tracker(it);
		items_sent++;
		in_valid <= 1'b0;
	endtask

	function automatic in_item_t blk(logic [31:0] sid, logic [2:0] p, logic [15:0] h,
			logic [15:0] l);
		in_item_t it;
		it.opcode = OP_BLOCK; it.coded_id = sid; it.priority_req = p;
		it.buffer_handle = h; it.block_length = l; it.now_ms = clock_ms;
		return it;
	endfunction

	function automatic in_item_t tick(logic [31:0] now);
		in_item_t it;
		it = '{opcode: OP_TICK, coded_id: $urandom, priority_req: 3'($urandom),
			buffer_handle: 16'($urandom), block_length: 16'($urandom), now_ms: now};
		return it;
	endfunction

	function automatic logic [31:0] split_id(logic [31:0] base, int tot, int idx);
		return base * 10000 + tot * 1000 + idx;
	endfunction

	// Wait for the block to drain before a register write.
	task automatic wait_idle();
		int guard;
		guard = 0;
		while (expected_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [31:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_timeout = v;
	endtask

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", out_data);
			end else begin
				out_item_t e;
				e = expected_results.pop_front();
				if (out_data !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", e, out_data);
				end
			end
		end
	end

	// Receiver stalls: random short and long gaps, plus a requested long hold-off.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_off <= 0;
			hold_ack <= 0;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_off <= 3000;
			out_ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 49) == 0) begin
			hold_off <= $urandom_range(20, 80);
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic test_singles();
		send_item(blk(32'd0, 3'd0, 16'h0000, 16'h0000));
		send_item(blk(32'd9999, 3'd7, 16'hFFFF, 16'hFFFF));
		send_item(blk(32'd4242, 3'd4, 16'hA5A5, 16'h5A5A));
	endtask

	task automatic test_split_frames();
		// Out of order, duplicate, index beyond total, differing total.
		send_item(blk(split_id(7, 3, 2), 3'd3, 16'h1111, 16'h0010));
		send_item(blk(split_id(7, 3, 2), 3'd1, 16'h2222, 16'h0020));
		send_item(blk(split_id(7, 3, 5), 3'd1, 16'h3333, 16'h0030));
		send_item(blk(split_id(7, 5, 0), 3'd6, 16'h4444, 16'h0040));
		send_item(blk(split_id(7, 3, 1), 3'd5, 16'h5555, 16'h0050));
		// Zero total and index beyond total with no context.
		send_item(blk(split_id(8, 0, 0), 3'd1, 16'd1, 16'd1));
		send_item(blk(split_id(8, 2, 999), 3'd1, 16'd1, 16'd1));
		// Largest frame, largest id.
		for (int i = 8; i >= 0; i--)
			send_item(blk(split_id(429495, 9, i), 3'd2, 16'($urandom), 16'($urandom)));
		send_item(blk(32'hFFFF_FFFF, 3'd7, 16'hFFFF, 16'hFFFF));
		send_item(blk(split_id(1, 1, 0), 3'd0, 16'd0, 16'd0));
	endtask

	task automatic test_table_full();
		for (int b = 0; b < NCTX + 1; b++)
			send_item(blk(split_id(100 + b, 2, 0), 3'(b), 16'(b), 16'(b)));
		clock_ms = clock_ms + 6000;
		send_item(tick(clock_ms));
	endtask

	task automatic test_timeouts();
		write_timeout(32'd0);
		send_item(blk(split_id(300, 4, 0), 3'd2, 16'd1, 16'd2));
		send_item(tick(clock_ms));
		send_item(tick(clock_ms + 1));
		write_timeout(32'hFFFF_FFFF);
		send_item(blk(split_id(301, 4, 0), 3'd2, 16'd1, 16'd2));
		send_item(tick(clock_ms - 1));
		send_item(tick(clock_ms + 32'h8000_0000));
		write_timeout(32'd1000);
		send_item(tick(clock_ms - 1));
	endtask

	task automatic test_random();
		int r;
		logic [31:0] base;
		int tot, idx;
		for (int k = 0; k < 50; k++) begin
			clock_ms = clock_ms + $urandom_range(0, 400);
			r = $urandom_range(0, 19);
			if (r == 0) begin
				send_item(tick(clock_ms));
			end else if (r == 1) begin
				send_item(blk($urandom, 3'($urandom), 16'($urandom), 16'($urandom)));
			end else if (r == 2) begin
				send_item(blk($urandom_range(0, 9999), 3'($urandom), 16'($urandom),
					16'($urandom)));
			end else begin
				// Well-formed frame parts from a small pool of bases.
				base = $urandom_range(1, 12) + (($urandom_range(0, 7) == 0) ? 429480 : 0);
				tot = 1 + (base % 9);
				idx = $urandom_range(0, tot - 1);
				if ($urandom_range(0, 15) == 0) idx = $urandom_range(0, 9);
				send_item(blk(split_id(base, tot, idx), 3'($urandom), 16'($urandom),
					16'($urandom)));
			end
		end
		clock_ms = clock_ms + 32'h1000_0000;
		send_item(tick(clock_ms));
	endtask

	task automatic test_backpressure();
		hold_req++;
		for (int i = 0; i < 6; i++)
			send_item(blk(split_id(500, 6, i), 3'd1, 16'(i), 16'(i)));
		for (int i = 0; i < 6; i++)
			send_item(blk(i, 3'd1, 16'(i), 16'(i)));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		hold_req = 0;
		mismatches = 0;
		results_seen = 0;
		items_sent = 0;
		clock_ms = 32'hFFFF_F000;
		m_timeout = TIMEOUT_RESET;
		for (int c = 0; c < NCTX; c++) begin
			m_valid[c] = 1'b0; m_map[c] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_singles();
		test_split_frames();
		test_table_full();
		test_timeouts();
		write_timeout(TIMEOUT_RESET);
		test_backpressure();
		test_random();
		wait_idle();
		$display("Sent %0d items and checked %0d results across singles, frames,",
			items_sent, results_seen);
		$display("ticks, table overflow, timeout extremes and output backpressure.");
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* files.f */
hdl/sbrt_pkg.sv
hdl/sbrt_id_decode.sv
hdl/split_block_reassembly_tracker_unit.sv
dv/tb_split_block_reassembly_tracker_unit.sv
